### rtl/psl_pkg.sv
package psl_pkg;

  localparam int ValueWidth  = 64;
  localparam int CountWidth  = 7;
  localparam int PosWidth    = 8;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_GET    = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic shift_up;
    logic shift_down;
  } cell_cmd_t;

endpackage

### rtl/psl_cell.sv
module psl_cell #(
  parameter int INDEX = 0,
  parameter int PW    = 8
) (
  input  logic                                clk,
  input  psl_pkg::cell_cmd_t                  cmd,
  input  logic [PW-1:0]                       pos,
  input  logic [psl_pkg::ValueWidth-1:0]      entry_value,
  input  logic [psl_pkg::ValueWidth-1:0]      left_value,
  input  logic [psl_pkg::ValueWidth-1:0]      right_value,
  input  logic [psl_pkg::ValueWidth-1:0]      rd_in,
  output logic [psl_pkg::ValueWidth-1:0]      value,
  output logic [psl_pkg::ValueWidth-1:0]      rd_out
);

  localparam logic [PW-1:0] Idx = PW'(INDEX);

  logic hit;
  assign hit = (Idx == pos);

  always_ff @(posedge clk) begin
    if (cmd.shift_up) begin
      if (Idx > pos) begin
        value <= left_value;
      end else if (hit) begin
        value <= entry_value;
      end
    end else if (cmd.shift_down) begin
      if (Idx >= pos) begin
        value <= right_value;
      end
    end
    // read word walks up the chain; the addressed cell drops its value in
    rd_out <= hit ? value : rd_in;
  end

endmodule

### rtl/positional_sequential_list.sv
// Ordered list in cells; insert and delete shift the cells from the position up at once.
// Insert, delete, errors and the unused mode: result strobe in the cycle after start,
// and a new request may follow in that same cycle.
// Get: the read word walks the cell chain, one cell a cycle, while busy is high.
// Synchronous active-high reset empties the list and sets capacity to 64;
// entry contents are not cleared. Results cannot be stalled by the receiver.
module positional_sequential_list #(
  parameter int DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         mode,
  input  logic [psl_pkg::PosWidth-1:0]       position,
  input  logic [psl_pkg::ValueWidth-1:0]     entry_value,
  input  logic                               cfg_we,
  input  logic [psl_pkg::CountWidth-1:0]     cfg_data,
  output logic                               done,
  output logic [1:0]                         status,
  output logic [psl_pkg::ValueWidth-1:0]     read_value,
  output logic [psl_pkg::CountWidth-1:0]     list_length
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = (AW > psl_pkg::PosWidth) ? AW : psl_pkg::PosWidth;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = psl_pkg::ValueWidth;
  localparam int NW = psl_pkg::CountWidth;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t state;

  logic [NW-1:0] entry_count;
  logic [NW-1:0] capacity;
  logic [PW-1:0] pos_q;
  logic [CW-1:0] sweep;

  logic [VW-1:0] cell_value [DEPTH];
  logic [VW-1:0] cell_rd    [DEPTH];

  logic               accept;
  logic               is_ins;
  logic               is_get;
  logic               is_del;
  logic [PW-1:0]      pos_ext;
  logic [PW-1:0]      cnt_ext;
  logic               in_range;
  logic               full;
  logic               ins_ok;
  logic               del_ok;
  logic [PW-1:0]      cell_pos;
  psl_pkg::cell_cmd_t cmd;
  psl_pkg::status_t   status_next;
  logic [NW-1:0]      entry_count_next;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign is_ins  = (mode == psl_pkg::MODE_INSERT);
  assign is_get  = (mode == psl_pkg::MODE_GET);
  assign is_del  = (mode == psl_pkg::MODE_DELETE);
  assign pos_ext = PW'(position);
  assign cnt_ext = PW'(entry_count);
  assign in_range = (pos_ext < cnt_ext);
  assign full    = (entry_count >= capacity) || (32'(entry_count) >= DEPTH);
  assign ins_ok  = is_ins && (entry_value != '0) && !full;
  assign del_ok  = is_del && in_range;

  always_comb begin
    if (state == S_READ) begin
      cell_pos = pos_q;
    end else if (is_ins && !in_range) begin
      cell_pos = cnt_ext;  // append past the end
    end else begin
      cell_pos = pos_ext;
    end
  end

  assign cmd.shift_up   = accept && ins_ok;
  assign cmd.shift_down = accept && del_ok;

  always_comb begin
    status_next = psl_pkg::ST_OK;
    if (is_ins) begin
      if (entry_value == '0) begin
        status_next = psl_pkg::ST_ZERO;
      end else if (full) begin
        status_next = psl_pkg::ST_FULL;
      end
    end else if (is_get || is_del) begin
      if (!in_range) begin
        status_next = psl_pkg::ST_RANGE;
      end
    end
  end

  always_comb begin
    entry_count_next = entry_count;
    if (ins_ok) begin
      entry_count_next = entry_count + NW'(1);
    end else if (del_ok) begin
      entry_count_next = entry_count - NW'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VW-1:0] left_v;
    logic [VW-1:0] right_v;
    logic [VW-1:0] rd_in_v;

    if (i == 0) begin : g_first
      assign left_v  = '0;
      assign rd_in_v = '0;
    end else begin : g_mid
      assign left_v  = cell_value[i-1];
      assign rd_in_v = cell_rd[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_nlast
      assign right_v = cell_value[i+1];
    end

    psl_cell #(
      .INDEX (i),
      .PW    (PW)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .pos         (cell_pos),
      .entry_value (entry_value),
      .left_value  (left_v),
      .right_value (right_v),
      .rd_in       (rd_in_v),
      .value       (cell_value[i]),
      .rd_out      (cell_rd[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      entry_count <= '0;
      capacity    <= NW'(64);
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_get && in_range) begin
              pos_q <= pos_ext;
              sweep <= '0;
              state <= S_READ;
            end else begin
              done        <= 1'b1;
              status      <= status_next;
              read_value  <= '0;
              list_length <= entry_count_next;
              entry_count <= entry_count_next;
            end
          end
        end
        S_READ: begin
          sweep <= sweep + CW'(1);
          // the last cell holds the addressed entry once the word has crossed the chain
          if (sweep == CW'(DEPTH)) begin
            done        <= 1'b1;
            status      <= psl_pkg::ST_OK;
            read_value  <= cell_rd[DEPTH-1];
            list_length <= entry_count;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### tb/testbench.sv
module testbench;
  import psl_pkg::*;

  localparam int Depth = 64;
  localparam int WatchdogLimit = 4000;
  localparam int SettleCycles = Depth + 8;
  localparam int MaxReported = 10;
  localparam logic [ValueWidth-1:0] AllOnes = '1;
  localparam logic [ValueWidth-1:0] TopBit = 64'h8000_0000_0000_0000;
  localparam logic [ValueWidth-1:0] Alternating = 64'h5555_5555_5555_5555;

  typedef struct packed {
    status_t status;
    logic [ValueWidth-1:0] read_value;
    logic [CountWidth-1:0] list_length;
  } list_result_t;

  typedef struct {
    bit is_cfg;
    logic [CountWidth-1:0] cfg_value;
    mode_t op;
    logic [PosWidth-1:0] position;
    logic [ValueWidth-1:0] entry_value;
    bit typed;
    list_result_t result;
  } list_row_t;

  typedef struct {
    int capacity;
    int insert_pct;
    int get_pct;
    int delete_pct;
    bit burst;
    int items;
  } list_phase_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] mode;
  logic [PosWidth-1:0] position;
  logic [ValueWidth-1:0] entry_value;
  logic cfg_we;
  logic [CountWidth-1:0] cfg_data;
  logic done;
  logic [1:0] status;
  logic [ValueWidth-1:0] read_value;
  logic [CountWidth-1:0] list_length;

  logic [ValueWidth-1:0] shadow_entries [Depth];
  int shadow_count;
  int shadow_capacity;
  list_result_t pending_results [$];
  list_row_t directed_rows [$];
  list_phase_t phases [$];
  int mismatches = 0;
  int idle_cycles = 0;

  positional_sequential_list #(
    .DEPTH(Depth)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .position(position),
    .entry_value(entry_value),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .done(done),
    .status(status),
    .read_value(read_value),
    .list_length(list_length)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one operation to the shadow list and return what the block should report.
  function automatic list_result_t apply_list_op(mode_t op, logic [PosWidth-1:0] pos_in,
                                                 logic [ValueWidth-1:0] value);
    list_result_t r;
    int pos;
    int limit;
    r.status = ST_OK;
    r.read_value = '0;
    pos = pos_in;
    limit = (shadow_capacity > Depth) ? Depth : shadow_capacity;
    case (op)
      MODE_INSERT: begin
        if (value == '0) begin
          r.status = ST_ZERO;
        end else if (shadow_count >= limit) begin
          r.status = ST_FULL;
        end else begin
          if (pos > shadow_count) pos = shadow_count;
          for (int i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i - 1];
          shadow_entries[pos] = value;
          shadow_count++;
        end
      end
      MODE_GET: begin
        if (pos >= shadow_count) r.status = ST_RANGE;
        else r.read_value = shadow_entries[pos];
      end
      MODE_DELETE: begin
        if (pos >= shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i + 1];
          shadow_count--;
          shadow_entries[shadow_count] = '0;
        end
      end
      default: ;
    endcase
    r.list_length = shadow_count[CountWidth-1:0];
    return r;
  endfunction

  function automatic void add_row(mode_t op, logic [PosWidth-1:0] pos,
                                  logic [ValueWidth-1:0] value, bit typed, status_t st,
                                  logic [ValueWidth-1:0] rd, logic [CountWidth-1:0] len);
    list_row_t r;
    r.is_cfg = 1'b0;
    r.cfg_value = '0;
    r.op = op;
    r.position = pos;
    r.entry_value = value;
    r.typed = typed;
    r.result = '{st, rd, len};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [CountWidth-1:0] value);
    list_row_t r;
    r.is_cfg = 1'b1;
    r.cfg_value = value;
    r.op = MODE_NONE;
    r.position = '0;
    r.entry_value = '0;
    r.typed = 1'b0;
    r.result = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_phase(int cap, int ins, int get, int del, bit burst, int items);
    list_phase_t p;
    p = '{cap, ins, get, del, burst, items};
    phases.push_back(p);
  endfunction

  // Entered and left at a falling edge.
  task automatic send_request(mode_t op, logic [PosWidth-1:0] pos,
                              logic [ValueWidth-1:0] value, int gap, bit typed,
                              list_result_t typed_result);
    list_result_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      mode <= 2'($urandom);
      position <= 8'($urandom);
      entry_value <= {$urandom, $urandom};
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    mode <= op;
    position <= pos;
    entry_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_list_op(op, pos, value);
    pending_results.push_back(typed ? typed_result : predicted);
    @(negedge clk);
  endtask

  // Hold off requests until every pending result has come back.
  task automatic wait_until_drained(int extra);
    start <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CountWidth-1:0] value);
    wait_until_drained(4);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_data <= 7'($urandom);
    shadow_capacity = value;
  endtask

  task automatic random_request(int ins_pct, int get_pct, int del_pct, bit burst);
    int roll;
    mode_t op;
    logic [PosWidth-1:0] pos;
    logic [ValueWidth-1:0] value;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) op = MODE_INSERT;
    else if (roll < ins_pct + get_pct) op = MODE_GET;
    else if (roll < ins_pct + get_pct + del_pct) op = MODE_DELETE;
    else op = MODE_NONE;
    case ($urandom_range(0, 9))
      0: pos = 8'hFF;
      1: pos = 8'($urandom);
      2: pos = 8'(shadow_count);
      default: pos = 8'($urandom_range(0, (shadow_count > 0) ? shadow_count - 1 : 0));
    endcase
    case ($urandom_range(0, 19))
      0: value = '0;
      1: value = AllOnes;
      2: value = 64'd1 << $urandom_range(0, 63);
      default: value = {$urandom, $urandom};
    endcase
    send_request(op, pos, value, burst ? 0 : $urandom_range(0, 9), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end
      if (done) begin
        if (pending_results.size() == 0) begin
          if (mismatches < MaxReported)
            $display("unexpected result: status %0d read %h length %0d",
                     status, read_value, list_length);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (want.status !== status || want.read_value !== read_value ||
              want.list_length !== list_length) begin
            if (mismatches < MaxReported)
              $display("mismatch: expected status %0d read %h length %0d, got %0d %h %0d",
                       want.status, want.read_value, want.list_length,
                       status, read_value, list_length);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    mode = MODE_NONE;
    position = '0;
    entry_value = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    shadow_count = 0;
    shadow_capacity = 64;
    foreach (shadow_entries[i]) shadow_entries[i] = '0;

    // Empty list, errors and the unused mode.
    add_row(MODE_GET, 8'd0, '0, 1'b1, ST_RANGE, '0, 7'd0);
    add_row(MODE_DELETE, 8'd0, '0, 1'b1, ST_RANGE, '0, 7'd0);
    add_row(MODE_INSERT, 8'd0, '0, 1'b1, ST_ZERO, '0, 7'd0);
    add_row(MODE_NONE, 8'hFF, AllOnes, 1'b1, ST_OK, '0, 7'd0);
    // Insert far past the end appends.
    add_row(MODE_INSERT, 8'hFF, AllOnes, 1'b1, ST_OK, '0, 7'd1);
    add_row(MODE_GET, 8'd0, '0, 1'b1, ST_OK, AllOnes, 7'd1);
    add_row(MODE_INSERT, 8'd0, 64'd1, 1'b1, ST_OK, '0, 7'd2);
    add_row(MODE_GET, 8'd1, '0, 1'b0, ST_OK, '0, '0);
    add_row(MODE_INSERT, 8'd1, TopBit, 1'b1, ST_OK, '0, 7'd3);
    add_row(MODE_GET, 8'd1, AllOnes, 1'b0, ST_OK, '0, '0);
    add_row(MODE_GET, 8'hFF, '0, 1'b1, ST_RANGE, '0, 7'd3);
    add_row(MODE_DELETE, 8'd3, '0, 1'b1, ST_RANGE, '0, 7'd3);
    add_row(MODE_INSERT, 8'd3, Alternating, 1'b1, ST_OK, '0, 7'd4);
    add_row(MODE_DELETE, 8'd0, '0, 1'b0, ST_OK, '0, '0);
    add_row(MODE_GET, 8'd2, '0, 1'b0, ST_OK, '0, '0);
    add_row(MODE_INSERT, 8'd0, '0, 1'b1, ST_ZERO, '0, 7'd3);
    add_row(MODE_DELETE, 8'd2, '0, 1'b1, ST_OK, '0, 7'd2);
    // Capacity at the length, zero, below the length, above the depth.
    add_cfg(7'd2);
    add_row(MODE_INSERT, 8'd0, AllOnes, 1'b1, ST_FULL, '0, 7'd2);
    add_cfg(7'd0);
    add_row(MODE_INSERT, 8'd0, 64'd1, 1'b1, ST_FULL, '0, 7'd2);
    add_cfg(7'd1);
    add_row(MODE_DELETE, 8'd0, '0, 1'b1, ST_OK, '0, 7'd1);
    add_row(MODE_INSERT, 8'd1, 64'd7, 1'b1, ST_FULL, '0, 7'd1);
    add_cfg(7'd127);
    add_row(MODE_INSERT, 8'd0, 64'd7, 1'b1, ST_OK, '0, 7'd2);
    add_row(MODE_GET, 8'd0, '0, 1'b0, ST_OK, '0, '0);

    add_phase(64, 70, 15, 12, 1'b0, 110);
    add_phase(127, 40, 30, 27, 1'b1, 90);
    add_phase(5, 20, 20, 57, 1'b0, 110);
    add_phase(0, 45, 25, 27, 1'b0, 70);
    add_phase(1, 45, 25, 27, 1'b1, 80);
    add_phase($urandom_range(0, 127), 65, 15, 17, 1'b0, 110);
    add_phase(64, 25, 20, 52, 1'b0, 110);
    add_phase(2, 45, 25, 27, 1'b1, 60);
    add_phase(64, 60, 20, 17, 1'b0, 60);

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_capacity(directed_rows[i].cfg_value);
      end else begin
        send_request(directed_rows[i].op, directed_rows[i].position,
                     directed_rows[i].entry_value, $urandom_range(0, 9),
                     directed_rows[i].typed, directed_rows[i].result);
      end
    end

    foreach (phases[p]) begin
      write_capacity(7'(phases[p].capacity));
      repeat (phases[p].items)
        random_request(phases[p].insert_pct, phases[p].get_pct, phases[p].delete_pct,
                       phases[p].burst);
    end

    wait_until_drained(SettleCycles);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/psl_pkg.sv
rtl/psl_cell.sv
rtl/positional_sequential_list.sv
tb/testbench.sv
